// ===== rtl/mvad_pkg.sv =====
// Shared types, codes and helper functions for the masked voxel array decoder.
// Used by the register block, the cell walker and the top level.
package mvad_pkg;

    localparam int unsigned PALETTE_DEPTH_DEF = 256;
    localparam int unsigned EXIST_BYTES_DEF   = 4096;
    localparam int unsigned DIM_BITS_DEF      = 16;

    localparam int unsigned PADDR_W = 5;

    // Command codes of an input transfer.
    localparam logic [1:0] CMD_PAL   = 2'd0;
    localparam logic [1:0] CMD_EXIST = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_BYTE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_VOXEL = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_CAP   = 2'd3;

    // Index width codes.
    localparam logic [1:0] IDX_DIRECT = 2'd0;
    localparam logic [1:0] IDX_8      = 2'd1;
    localparam logic [1:0] IDX_16     = 2'd2;
    localparam logic [1:0] IDX_32     = 2'd3;

    // Color format codes.
    localparam logic [1:0] FMT_RGB  = 2'd0;
    localparam logic [1:0] FMT_ARGB = 2'd1;
    localparam logic [1:0] FMT_GRAY = 2'd2;
    localparam logic [1:0] FMT_AG   = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_COLOR_FORMAT = 3'd0;
    localparam logic [2:0] REG_INDEX_WIDTH  = 3'd1;
    localparam logic [2:0] REG_PALETTE_SIZE = 3'd2;
    localparam logic [2:0] REG_EXIST_EN     = 3'd3;
    localparam logic [2:0] REG_SIZE_X       = 3'd4;
    localparam logic [2:0] REG_SIZE_Y       = 3'd5;
    localparam logic [2:0] REG_SIZE_Z       = 3'd6;

    typedef struct packed {
        logic [1:0]  color_format;
        logic [1:0]  index_width;
        logic [8:0]  palette_size;
        logic        existence_enabled;
        logic [16:0] size_x;
        logic [16:0] size_y;
        logic [16:0] size_z;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic step;
    } walk_cmd_t;

    function automatic logic [2:0] color_bytes(input logic [1:0] fmt);
        logic [2:0] n;
        case (fmt)
            FMT_RGB:  n = 3'd3;
            FMT_ARGB: n = 3'd4;
            FMT_GRAY: n = 3'd1;
            default:  n = 3'd2;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] index_bytes(input logic [1:0] iw);
        logic [2:0] n;
        case (iw)
            IDX_8:   n = 3'd1;
            IDX_16:  n = 3'd2;
            IDX_32:  n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Turns left-aligned color bytes into packed ARGB.
    function automatic logic [31:0] decode_color(input logic [31:0] w, input logic [1:0] fmt);
        logic [31:0] c;
        case (fmt)
            FMT_RGB:  c = {8'hFF, w[31:24], w[23:16], w[15:8]};
            FMT_ARGB: c = w;
            FMT_GRAY: c = {8'hFF, w[31:24], w[31:24], w[31:24]};
            default:  c = {w[31:24], w[23:16], w[23:16], w[23:16]};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/mvad_if.sv =====
// Valid/ready channel interfaces for the decoder's input and result streams.
// Depends on nothing beyond the language itself.
interface mvad_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [7:0]         byte_in;
    logic [11:0]        table_addr;
    logic [31:0]        palette_word;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;

    modport source (output valid, cmd, byte_in, table_addr, palette_word,
                    origin_x, origin_y, origin_z, input ready);
    modport sink (input valid, cmd, byte_in, table_addr, palette_word,
                  origin_x, origin_y, origin_z, output ready);
endinterface

interface mvad_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        argb;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, pos_x, pos_y, pos_z, argb, status, last, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, argb, status, last, output ready);
endinterface

// ===== rtl/mvad_regs.sv =====
// APB-style configuration registers of the decoder.
// Depends on mvad_pkg for the register indexes and the cfg_t struct.
module mvad_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mvad_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output mvad_pkg::cfg_t               cfg
);

    mvad_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_format      <= mvad_pkg::FMT_RGB;
            cfg_reg.index_width       <= mvad_pkg::IDX_DIRECT;
            cfg_reg.palette_size      <= 9'd1;
            cfg_reg.existence_enabled <= 1'b0;
            cfg_reg.size_x            <= 17'd1;
            cfg_reg.size_y            <= 17'd1;
            cfg_reg.size_z            <= 17'd1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mvad_pkg::REG_COLOR_FORMAT: cfg_reg.color_format      <= pwdata[1:0];
                mvad_pkg::REG_INDEX_WIDTH:  cfg_reg.index_width       <= pwdata[1:0];
                mvad_pkg::REG_PALETTE_SIZE: cfg_reg.palette_size      <= pwdata[8:0];
                mvad_pkg::REG_EXIST_EN:     cfg_reg.existence_enabled <= pwdata[0];
                mvad_pkg::REG_SIZE_X:       cfg_reg.size_x            <= pwdata[16:0];
                mvad_pkg::REG_SIZE_Y:       cfg_reg.size_y            <= pwdata[16:0];
                mvad_pkg::REG_SIZE_Z:       cfg_reg.size_z            <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mvad_pkg::REG_COLOR_FORMAT: prdata = {30'd0, cfg_reg.color_format};
            mvad_pkg::REG_INDEX_WIDTH:  prdata = {30'd0, cfg_reg.index_width};
            mvad_pkg::REG_PALETTE_SIZE: prdata = {23'd0, cfg_reg.palette_size};
            mvad_pkg::REG_EXIST_EN:     prdata = {31'd0, cfg_reg.existence_enabled};
            mvad_pkg::REG_SIZE_X:       prdata = {15'd0, cfg_reg.size_x};
            mvad_pkg::REG_SIZE_Y:       prdata = {15'd0, cfg_reg.size_y};
            mvad_pkg::REG_SIZE_Z:       prdata = {15'd0, cfg_reg.size_z};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/mvad_walker.sv =====
// Cell walker: the shared step unit that moves x, y, z and the bitmap cell index.
// Depends on mvad_pkg for the walk_cmd_t struct.
module mvad_walker
#(
    parameter int unsigned DIM_BITS    = mvad_pkg::DIM_BITS_DEF,
    parameter int unsigned EXIST_BYTES = mvad_pkg::EXIST_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mvad_pkg::walk_cmd_t           cmd,
    input  logic [16:0]                   size_x,
    input  logic [16:0]                   size_y,
    input  logic [16:0]                   size_z,
    output logic [DIM_BITS-1:0]           local_x,
    output logic [DIM_BITS-1:0]           local_y,
    output logic [DIM_BITS-1:0]           local_z,
    output logic [$clog2(EXIST_BYTES*8):0] cell_index,
    output logic                          adv_ok,
    output logic                          is_final
);

    localparam int unsigned EW  = DIM_BITS + 1;
    localparam int unsigned CIW = $clog2(EXIST_BYTES*8) + 1;
    localparam logic [CIW-1:0] CAP = CIW'(EXIST_BYTES*8);

    logic [DIM_BITS-1:0] x_reg, y_reg, z_reg;
    logic [CIW-1:0]      ci_reg;
    logic [EW-1:0]       ext_x, ext_y, ext_z;
    logic [EW-1:0]       x1, y1, z1;
    logic                wrap_x, wrap_y;

    // A size of zero acts as one; sizes beyond the coordinate range clamp.
    function automatic logic [EW-1:0] extent(input logic [16:0] s);
        logic [33:0] lim;
        logic [33:0] v;
        lim = 34'd1 << DIM_BITS;
        v   = {17'd0, s};
        if (v == 34'd0)
        begin
            v = 34'd1;
        end
        if (v > lim)
        begin
            v = lim;
        end
        return v[EW-1:0];
    endfunction

    assign ext_x = extent(size_x);
    assign ext_y = extent(size_y);
    assign ext_z = extent(size_z);
    assign x1    = {1'b0, x_reg} + 1'b1;
    assign y1    = {1'b0, y_reg} + 1'b1;
    assign z1    = {1'b0, z_reg} + 1'b1;
    assign wrap_x = x1 >= ext_x;
    assign wrap_y = y1 >= ext_y;

    assign adv_ok   = !(wrap_x && wrap_y && (z1 >= ext_z));
    assign is_final = (x1 == ext_x) && (y1 == ext_y) && (z1 == ext_z);

    assign local_x    = x_reg;
    assign local_y    = y_reg;
    assign local_z    = z_reg;
    assign cell_index = ci_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            z_reg  <= '0;
            ci_reg <= '0;
        end
        else if (cmd.clear)
        begin
            x_reg  <= '0;
            y_reg  <= '0;
            z_reg  <= '0;
            ci_reg <= '0;
        end
        else if (cmd.step)
        begin
            // The index only needs to tell cells past the bitmap apart.
            if (ci_reg < CAP)
            begin
                ci_reg <= ci_reg + 1'b1;
            end
            if (!wrap_x)
            begin
                x_reg <= x1[DIM_BITS-1:0];
            end
            else
            begin
                x_reg <= '0;
                if (!wrap_y)
                begin
                    y_reg <= y1[DIM_BITS-1:0];
                end
                else
                begin
                    y_reg <= '0;
                    z_reg <= z1[DIM_BITS-1:0];
                end
            end
        end
    end

endmodule

// ===== rtl/masked_voxel_array_decoder.sv =====
// Masked voxel array decoder: table writes, array starts and content bytes with no active
// array are handled in idle; any other content byte passes the gather state, and an index
// byte with a palette lookup (one palette memory read) also the palette state. Masked mode
// checks each cell visited in the capacity and bit states, with one bitmap memory read and
// one walker step each. One transfer is in work at a time. rst_n is asynchronous and clears
// control state and the configuration registers; palette and bitmap memories are not cleared.
module masked_voxel_array_decoder
#(
    parameter int unsigned PALETTE_DEPTH = mvad_pkg::PALETTE_DEPTH_DEF,
    parameter int unsigned EXIST_BYTES   = mvad_pkg::EXIST_BYTES_DEF,
    parameter int unsigned DIM_BITS      = mvad_pkg::DIM_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    mvad_in_if.sink                      in_ch,
    mvad_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mvad_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int unsigned PAW = $clog2(PALETTE_DEPTH);
    localparam int unsigned BAW = $clog2(EXIST_BYTES);
    localparam int unsigned CIW = $clog2(EXIST_BYTES*8) + 1;
    localparam logic [CIW-1:0] CAP = CIW'(EXIST_BYTES*8);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CAP    = 3'd1;
    localparam logic [2:0] S_BIT    = 3'd2;
    localparam logic [2:0] S_GATHER = 3'd3;
    localparam logic [2:0] S_PAL    = 3'd4;

    mvad_pkg::cfg_t      cfg;
    mvad_pkg::walk_cmd_t wcmd;

    logic [DIM_BITS-1:0] local_x, local_y, local_z;
    logic [CIW-1:0]      cell_index;
    logic                adv_ok, is_final;

    // The palette and the existence bitmap are plain memories with registered reads.
    logic [31:0] palette_mem [PALETTE_DEPTH];
    logic [7:0]  bitmap_mem  [EXIST_BYTES];

    logic [2:0]  state_reg, state_next;
    logic        active_reg, active_next;
    logic [7:0]  byte_reg, byte_next;
    logic [31:0] gather_reg, gather_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] org_x_reg, org_x_next, org_y_reg, org_y_next, org_z_reg, org_z_next;
    logic [7:0]  bm_q_reg;
    logic [31:0] pal_q_reg;

    logic        out_valid_reg;
    logic [31:0] pos_x_reg, pos_y_reg, pos_z_reg, argb_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    logic        emit;
    logic [31:0] e_pos_x, e_pos_y, e_pos_z, e_argb;
    logic [1:0]  e_status;
    logic        e_last;

    logic        can_emit, accept;
    logic        pal_we, bm_we, pal_re, bm_re;
    logic [PAW-1:0] pal_raddr;
    logic [31:0] taddr32;
    logic [31:0] g_new;
    logic [2:0]  cnt_new, need_col, need_idx;
    logic [31:0] eff_size, pal_size32;
    logic [31:0] shifted;
    logic        cell_bit;

    mvad_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mvad_walker
    #(
        .DIM_BITS    (DIM_BITS),
        .EXIST_BYTES (EXIST_BYTES)
    )
    u_walker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (wcmd),
        .size_x     (cfg.size_x),
        .size_y     (cfg.size_y),
        .size_z     (cfg.size_z),
        .local_x    (local_x),
        .local_y    (local_y),
        .local_z    (local_z),
        .cell_index (cell_index),
        .adv_ok     (adv_ok),
        .is_final   (is_final)
    );

    // The sequencer takes a new transfer only when it is back in idle.
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign can_emit    = !out_valid_reg || out_ch.ready;
    assign taddr32     = {20'd0, in_ch.table_addr};

    // Byte gathering: the new byte enters at the bottom, the count wraps at eight.
    assign g_new      = {gather_reg[23:0], byte_reg};
    assign cnt_new    = count_reg + 3'd1;
    assign need_col   = mvad_pkg::color_bytes(cfg.color_format);
    assign need_idx   = mvad_pkg::index_bytes(cfg.index_width);
    assign pal_size32 = {23'd0, cfg.palette_size};
    assign eff_size   = (pal_size32 > 32'(PALETTE_DEPTH)) ? 32'(PALETTE_DEPTH) : pal_size32;
    assign cell_bit   = bm_q_reg[3'd7 - cell_index[2:0]];

    // Direct color bytes are left aligned before decoding.
    always_comb
    begin
        case (need_col)
            3'd1:    shifted = g_new << 24;
            3'd2:    shifted = g_new << 16;
            3'd3:    shifted = g_new << 8;
            default: shifted = g_new;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        byte_next   = byte_reg;
        gather_next = gather_reg;
        count_next  = count_reg;
        org_x_next  = org_x_reg;
        org_y_next  = org_y_reg;
        org_z_next  = org_z_reg;
        wcmd        = '0;
        pal_we      = 1'b0;
        bm_we       = 1'b0;
        pal_re      = 1'b0;
        bm_re       = 1'b0;
        pal_raddr   = '0;
        emit        = 1'b0;
        e_pos_x     = org_x_reg + 32'(local_x);
        e_pos_y     = org_y_reg + 32'(local_y);
        e_pos_z     = org_z_reg + 32'(local_z);
        e_argb      = 32'd0;
        e_status    = mvad_pkg::ST_VOXEL;
        e_last      = is_final;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.cmd)
                        mvad_pkg::CMD_PAL:
                        begin
                            pal_we = taddr32 < 32'(PALETTE_DEPTH);
                        end
                        mvad_pkg::CMD_EXIST:
                        begin
                            bm_we = taddr32 < 32'(EXIST_BYTES);
                        end
                        mvad_pkg::CMD_START:
                        begin
                            // A start also abandons any array still in progress.
                            org_x_next  = in_ch.origin_x;
                            org_y_next  = in_ch.origin_y;
                            org_z_next  = in_ch.origin_z;
                            wcmd.clear  = 1'b1;
                            gather_next = 32'd0;
                            count_next  = 3'd0;
                            active_next = 1'b1;
                        end
                        default:
                        begin
                            // Content bytes with no active array are dropped.
                            if (active_reg)
                            begin
                                byte_next  = in_ch.byte_in;
                                state_next = cfg.existence_enabled ? S_CAP : S_GATHER;
                            end
                        end
                    endcase
                end
            end

            S_CAP:
            begin
                if (cell_index >= CAP)
                begin
                    if (can_emit)
                    begin
                        emit        = 1'b1;
                        e_status    = mvad_pkg::ST_CAP;
                        e_last      = 1'b1;
                        e_pos_x     = 32'd0;
                        e_pos_y     = 32'd0;
                        e_pos_z     = 32'd0;
                        active_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    bm_re      = 1'b1;
                    state_next = S_BIT;
                end
            end

            S_BIT:
            begin
                if (cell_bit)
                begin
                    state_next = S_GATHER;
                end
                else if (!adv_ok)
                begin
                    // Ran off the end of the array without finding a present cell.
                    if (can_emit)
                    begin
                        emit        = 1'b1;
                        e_status    = mvad_pkg::ST_DONE;
                        e_last      = 1'b1;
                        e_pos_x     = 32'd0;
                        e_pos_y     = 32'd0;
                        e_pos_z     = 32'd0;
                        active_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    wcmd.step  = 1'b1;
                    state_next = S_CAP;
                end
            end

            S_GATHER:
            begin
                if (cfg.index_width == mvad_pkg::IDX_DIRECT)
                begin
                    if (cnt_new < need_col)
                    begin
                        gather_next = g_new;
                        count_next  = cnt_new;
                        state_next  = S_IDLE;
                    end
                    else if (can_emit)
                    begin
                        emit   = 1'b1;
                        e_argb = mvad_pkg::decode_color(shifted, cfg.color_format);
                    end
                end
                else if (cfg.palette_size == 9'd1)
                begin
                    // Single-color array: entry zero, the byte itself is not used.
                    pal_re     = 1'b1;
                    state_next = S_PAL;
                end
                else if (cnt_new < need_idx)
                begin
                    gather_next = g_new;
                    count_next  = cnt_new;
                    state_next  = S_IDLE;
                end
                else if (g_new >= eff_size)
                begin
                    if (can_emit)
                    begin
                        emit     = 1'b1;
                        e_status = mvad_pkg::ST_RANGE;
                    end
                end
                else
                begin
                    pal_re     = 1'b1;
                    pal_raddr  = g_new[PAW-1:0];
                    state_next = S_PAL;
                end
            end

            S_PAL:
            begin
                if (can_emit)
                begin
                    emit   = 1'b1;
                    e_argb = mvad_pkg::decode_color(pal_q_reg, cfg.color_format);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Every voxel or range result consumes the cell and moves the walker on.
        if (emit && (e_status == mvad_pkg::ST_VOXEL || e_status == mvad_pkg::ST_RANGE))
        begin
            gather_next = 32'd0;
            count_next  = 3'd0;
            wcmd.step   = 1'b1;
            state_next  = S_IDLE;
            if (!adv_ok || is_final)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            palette_mem[taddr32[PAW-1:0]] <= in_ch.palette_word;
        end
        if (pal_re)
        begin
            pal_q_reg <= palette_mem[pal_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bitmap_mem[taddr32[BAW-1:0]] <= in_ch.byte_in;
        end
        if (bm_re)
        begin
            bm_q_reg <= bitmap_mem[cell_index[CIW-2:3]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            byte_reg      <= 8'd0;
            gather_reg    <= 32'd0;
            count_reg     <= 3'd0;
            org_x_reg     <= 32'd0;
            org_y_reg     <= 32'd0;
            org_z_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            byte_reg   <= byte_next;
            gather_reg <= gather_next;
            count_reg  <= count_next;
            org_x_reg  <= org_x_next;
            org_y_reg  <= org_y_next;
            org_z_reg  <= org_z_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result register holds its payload until the transfer completes.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pos_x_reg  <= e_pos_x;
            pos_y_reg  <= e_pos_y;
            pos_z_reg  <= e_pos_z;
            argb_reg   <= e_argb;
            status_reg <= e_status;
            last_reg   <= e_last;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.pos_x  = pos_x_reg;
    assign out_ch.pos_y  = pos_y_reg;
    assign out_ch.pos_z  = pos_z_reg;
    assign out_ch.argb   = argb_reg;
    assign out_ch.status = status_reg;
    assign out_ch.last   = last_reg;

`ifndef SYNTH
    // An array that ends early always closes with last set.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == mvad_pkg::ST_DONE || status_reg == mvad_pkg::ST_CAP))
        |-> last_reg)
        else $error("early array end without last");

    // The bitmap is never looked up at or beyond its capacity.
    a_bit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIT) |-> (cell_index < CAP))
        else $error("bitmap read past capacity");

    // A palette lookup only follows the gather step.
    a_pal_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAL) |-> ($past(state_reg) == S_GATHER || $past(state_reg) == S_PAL))
        else $error("palette state entered out of order");

    // After an early-end result the array no longer accepts content.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (e_status == mvad_pkg::ST_DONE || e_status == mvad_pkg::ST_CAP))
        |=> !active_reg)
        else $error("array still active after early end");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the masked voxel array decoder.
// Depends on rtl/mvad_pkg.sv, rtl/mvad_if.sv and rtl/masked_voxel_array_decoder.sv.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned PAL_DEPTH  = mvad_pkg::PALETTE_DEPTH_DEF;
    localparam int unsigned MAP_BYTES  = mvad_pkg::EXIST_BYTES_DEF;
    // The front of the bitmap is filled at the outset; masked arrays stay within it.
    localparam int unsigned MAP_FILL   = 64;
    localparam int unsigned AXIS_LIMIT = 1 << mvad_pkg::DIM_BITS_DEF;
    // Longest legal silence is a masked walk over the whole bitmap, plus receiver stalls;
    // the limit is several times that.
    localparam int unsigned IDLE_LIMIT = 300000;
    localparam int unsigned ITEM_GOAL  = 1050;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  byte_in;
        logic [11:0] table_addr;
        logic [31:0] palette_word;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
    } cmd_item_t;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] argb;
        logic [1:0]  status;
        logic        last;
    } voxel_t;

    // The scoreboard holds a cycle-free model of the decoder: its own copy of the
    // palette, the bitmap, the walk position and the registers. Every accepted input
    // transfer is run through it, and any result it produces is queued for checking.
    class voxel_scoreboard;
        logic [31:0]     palette[PAL_DEPTH];
        logic [7:0]      bitmap[MAP_BYTES];
        logic [1:0]      fmt;
        logic [1:0]      idx_w;
        logic [8:0]      pal_size;
        logic            masked;
        logic [16:0]     dim[3];
        longint unsigned loc[3];
        longint unsigned walk_pos;
        logic [31:0]     origin[3];
        logic [31:0]     gather;
        int unsigned     gathered;
        bit              active;
        voxel_t          voxel_q[$];
        int              mismatches;
        int              checked;
        int              n_status[4];

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                mvad_pkg::REG_COLOR_FORMAT: fmt = v[1:0];
                mvad_pkg::REG_INDEX_WIDTH:  idx_w = v[1:0];
                mvad_pkg::REG_PALETTE_SIZE: pal_size = v[8:0];
                mvad_pkg::REG_EXIST_EN:     masked = v[0];
                mvad_pkg::REG_SIZE_X:       dim[0] = v[16:0];
                mvad_pkg::REG_SIZE_Y:       dim[1] = v[16:0];
                mvad_pkg::REG_SIZE_Z:       dim[2] = v[16:0];
                default: ;
            endcase
        endfunction

        function new();
            active = 0;
            gather = '0;
            gathered = 0;
            walk_pos = 0;
            mismatches = 0;
            checked = 0;
            for (int i = 0; i < 3; i++)
            begin
                loc[i] = 0;
                origin[i] = '0;
            end
            for (int i = 0; i < 4; i++) n_status[i] = 0;
            write_reg(mvad_pkg::REG_COLOR_FORMAT, mvad_pkg::FMT_RGB);
            write_reg(mvad_pkg::REG_INDEX_WIDTH, mvad_pkg::IDX_DIRECT);
            write_reg(mvad_pkg::REG_PALETTE_SIZE, 1);
            write_reg(mvad_pkg::REG_EXIST_EN, 0);
            write_reg(mvad_pkg::REG_SIZE_X, 1);
            write_reg(mvad_pkg::REG_SIZE_Y, 1);
            write_reg(mvad_pkg::REG_SIZE_Z, 1);
        endfunction

        // A zero extent behaves as one, anything past the axis range is clamped.
        function longint unsigned extent(int axis);
            longint unsigned v;
            v = dim[axis];
            if (v == 0) v = 1;
            if (v > AXIS_LIMIT) v = AXIS_LIMIT;
            return v;
        endfunction

        function longint unsigned cells();
            return extent(0) * extent(1) * extent(2);
        endfunction

        function int unsigned color_len(logic [1:0] f);
            case (f)
                mvad_pkg::FMT_RGB:  return 3;
                mvad_pkg::FMT_ARGB: return 4;
                mvad_pkg::FMT_GRAY: return 1;
                default:            return 2;
            endcase
        endfunction

        function int unsigned index_len(logic [1:0] w);
            case (w)
                mvad_pkg::IDX_8:  return 1;
                mvad_pkg::IDX_16: return 2;
                mvad_pkg::IDX_32: return 4;
                default:          return 0;
            endcase
        endfunction

        // Bytes arrive left aligned; gray formats replicate one byte into R, G and B.
        function logic [31:0] to_argb(logic [31:0] w);
            case (fmt)
                mvad_pkg::FMT_RGB:  return {8'hFF, w[31:8]};
                mvad_pkg::FMT_ARGB: return w;
                mvad_pkg::FMT_GRAY: return {8'hFF, {3{w[31:24]}}};
                default:            return {w[31:24], {3{w[23:16]}}};
            endcase
        endfunction

        // Steps x fastest, then y, then z; returns 0 once the walk runs off the end.
        function bit step_cell();
            walk_pos++;
            loc[0]++;
            if (loc[0] >= extent(0))
            begin
                loc[0] = 0;
                loc[1]++;
                if (loc[1] >= extent(1))
                begin
                    loc[1] = 0;
                    loc[2]++;
                    if (loc[2] >= extent(2)) return 0;
                end
            end
            return 1;
        endfunction

        function void queue_voxel(logic [31:0] argb, logic [1:0] st, bit last, bit placed);
            voxel_t v;
            v.pos_x = placed ? origin[0] + loc[0][31:0] : '0;
            v.pos_y = placed ? origin[1] + loc[1][31:0] : '0;
            v.pos_z = placed ? origin[2] + loc[2][31:0] : '0;
            v.argb = argb;
            v.status = st;
            v.last = last;
            voxel_q.push_back(v);
        endfunction

        function void note_input(cmd_item_t it);
            int unsigned need;
            logic [31:0] argb;
            logic [1:0]  st;
            bit          last;
            longint unsigned lim;
            case (it.cmd)
                mvad_pkg::CMD_PAL:
                begin
                    if (it.table_addr < PAL_DEPTH) palette[it.table_addr] = it.palette_word;
                    return;
                end
                mvad_pkg::CMD_EXIST:
                begin
                    if (it.table_addr < MAP_BYTES) bitmap[it.table_addr] = it.byte_in;
                    return;
                end
                mvad_pkg::CMD_START:
                begin
                    origin[0] = it.origin_x;
                    origin[1] = it.origin_y;
                    origin[2] = it.origin_z;
                    for (int i = 0; i < 3; i++) loc[i] = 0;
                    walk_pos = 0;
                    gather = '0;
                    gathered = 0;
                    active = 1;
                    return;
                end
                default: ;
            endcase
            if (!active) return;

            // Masked mode: skip absent cells before the byte is taken.
            if (masked)
            begin
                forever
                begin
                    if (walk_pos >= longint'(MAP_BYTES) * 8)
                    begin
                        active = 0;
                        queue_voxel('0, mvad_pkg::ST_CAP, 1, 0);
                        return;
                    end
                    if (bitmap[walk_pos >> 3][7 - (walk_pos & 7)]) break;
                    if (!step_cell())
                    begin
                        active = 0;
                        queue_voxel('0, mvad_pkg::ST_DONE, 1, 0);
                        return;
                    end
                end
            end

            st = mvad_pkg::ST_VOXEL;
            if (idx_w == mvad_pkg::IDX_DIRECT)
            begin
                need = color_len(fmt);
                gather = {gather[23:0], it.byte_in};
                gathered = (gathered + 1) & 7;
                if (gathered < need) return;
                argb = to_argb(gather << (8 * (4 - need)));
            end
            else if (pal_size == 1)
            begin
                argb = to_argb(palette[0]);
            end
            else
            begin
                need = index_len(idx_w);
                gather = {gather[23:0], it.byte_in};
                gathered = (gathered + 1) & 7;
                if (gathered < need) return;
                lim = (pal_size > PAL_DEPTH) ? PAL_DEPTH : pal_size;
                if (gather >= lim)
                begin
                    argb = '0;
                    st = mvad_pkg::ST_RANGE;
                end
                else
                    argb = to_argb(palette[gather[7:0]]);
            end
            gather = '0;
            gathered = 0;
            last = (loc[0] + 1 == extent(0)) && (loc[1] + 1 == extent(1)) &&
                   (loc[2] + 1 == extent(2));
            queue_voxel(argb, st, last, 1);
            if (!step_cell() || last) active = 0;
        endfunction

        function void check_result(voxel_t got);
            voxel_t want;
            checked++;
            n_status[got.status]++;
            if (voxel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result pos=(%0h,%0h,%0h) argb=%h status=%0d",
                             got.pos_x, got.pos_y, got.pos_z, got.argb, got.status);
                return;
            end
            want = voxel_q.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.pos_z !== want.pos_z || got.argb !== want.argb ||
                got.status !== want.status || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d expected pos=(%h,%h,%h) argb=%h st=%0d last=%0d",
                             checked, want.pos_x, want.pos_y, want.pos_z, want.argb,
                             want.status, want.last);
                    $display("       actual        pos=(%h,%h,%h) argb=%h st=%0d last=%0d",
                             got.pos_x, got.pos_y, got.pos_z, got.argb, got.status, got.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [mvad_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mvad_in_if  in_ch ();
    mvad_out_if out_ch ();

    masked_voxel_array_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    voxel_scoreboard voxels = new();
    bit          calm;          // when set, neither side idles
    int          stall_left;
    int unsigned idle_cycles;
    int unsigned items_sent;
    int unsigned arrays_started;
    int unsigned phases_run;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random back-pressure, with every transfer checked at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            voxel_t got;
            got.pos_x = out_ch.pos_x;
            got.pos_y = out_ch.pos_y;
            got.pos_z = out_ch.pos_z;
            got.argb = out_ch.argb;
            got.status = out_ch.status;
            got.last = out_ch.last;
            voxels.check_result(got);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            out_ch.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
                $display("tb_top failed");
                $finish;
            end
        end
        else
            idle_cycles = 0;
    end

    // Called just after a rising edge. Drives one item and returns at its transfer edge.
    task automatic send_item(cmd_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= it.cmd;
        in_ch.byte_in <= it.byte_in;
        in_ch.table_addr <= it.table_addr;
        in_ch.palette_word <= it.palette_word;
        in_ch.origin_x <= it.origin_x;
        in_ch.origin_y <= it.origin_y;
        in_ch.origin_z <= it.origin_z;
        do @(posedge clk); while (!in_ch.ready);
        voxels.note_input(it);
        items_sent++;
        if (it.cmd == mvad_pkg::CMD_START) arrays_started++;
    endtask

    // Any field not used by a command still carries random bits.
    function automatic cmd_item_t make_item(logic [1:0] cmd);
        cmd_item_t it;
        it.cmd = cmd;
        it.byte_in = $urandom_range(0, 255);
        it.table_addr = $urandom_range(0, 4095);
        it.palette_word = $urandom;
        it.origin_x = $urandom;
        it.origin_y = $urandom;
        it.origin_z = $urandom;
        return it;
    endfunction

    task automatic send_table(logic [1:0] cmd, int addr, logic [31:0] data);
        cmd_item_t it;
        it = make_item(cmd);
        it.table_addr = addr;
        it.byte_in = data[7:0];
        it.palette_word = data;
        send_item(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        cmd_item_t it;
        it = make_item(mvad_pkg::CMD_BYTE);
        it.byte_in = b;
        send_item(it);
    endtask

    // Origins lean toward the signed extremes so that the position adders wrap.
    task automatic start_array();
        cmd_item_t it;
        it = make_item(mvad_pkg::CMD_START);
        case ($urandom_range(0, 5))
            0: it.origin_x = 32'h7FFF_FFFF;
            1: it.origin_y = 32'h8000_0000;
            2: it.origin_z = 32'hFFFF_FFFF;
            3:
            begin
                it.origin_x = '0;
                it.origin_y = '0;
                it.origin_z = '0;
            end
            default: ;
        endcase
        send_item(it);
    endtask

    // Setup and access cycles; the register takes the value at the access edge.
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= mvad_pkg::PADDR_W'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        voxels.write_reg(idx, v);
    endtask

    // Waits for every expected result, then for a partial byte's walk over absent
    // cells to finish, which gives no result but keeps the block busy.
    task automatic wait_quiet();
        longint unsigned n;
        in_ch.valid <= 1'b0;
        while (voxels.voxel_q.size() != 0) @(posedge clk);
        n = voxels.cells();
        if (n > MAP_FILL * 8) n = MAP_FILL * 8;
        repeat (2 * n + 20) @(posedge clk);
    endtask

    task automatic configure(logic [1:0] f, logic [1:0] w, logic [8:0] ps, logic en,
                             logic [16:0] sx, logic [16:0] sy, logic [16:0] sz);
        wait_quiet();
        write_reg(mvad_pkg::REG_COLOR_FORMAT, f);
        write_reg(mvad_pkg::REG_INDEX_WIDTH, w);
        write_reg(mvad_pkg::REG_PALETTE_SIZE, ps);
        write_reg(mvad_pkg::REG_EXIST_EN, en);
        write_reg(mvad_pkg::REG_SIZE_X, sx);
        write_reg(mvad_pkg::REG_SIZE_Y, sy);
        write_reg(mvad_pkg::REG_SIZE_Z, sz);
        phases_run++;
    endtask

    function automatic logic [16:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 4);
        if (r < 95) return $urandom_range(1, 7);
        return $urandom_range(0, 131071);
    endfunction

    // Extent of one axis as the block sees it.
    function automatic longint unsigned axis_len(logic [16:0] s);
        longint unsigned v;
        v = s;
        if (v == 0) v = 1;
        if (v > AXIS_LIMIT) v = AXIS_LIMIT;
        return v;
    endfunction

    // One phase of arrays under the current settings. Each cell gets one well-formed
    // group of bytes (a color or a big-endian index); a few noise items are mixed in,
    // and starts in the middle of an array abandon it.
    task automatic run_arrays(int n_arrays);
        int unsigned     per_cell;
        int unsigned     lim;
        longint unsigned n_cells;
        logic [31:0]     idx;
        int              map_len;
        cmd_item_t       it;
        for (int i = 0; i < 3; i++)
            send_table(mvad_pkg::CMD_PAL, $urandom_range(0, 511), $urandom);
        n_cells = voxels.cells();
        if (n_cells > 40) n_cells = 40;
        map_len = (n_cells + 7) / 8 + 1;
        for (int i = 0; i < map_len; i++)
        begin
            case ($urandom_range(0, 5))
                0, 1: send_table(mvad_pkg::CMD_EXIST, i, 32'hFF);
                2:    send_table(mvad_pkg::CMD_EXIST, i, 32'h00);
                default: send_table(mvad_pkg::CMD_EXIST, i, $urandom_range(0, 255));
            endcase
        end
        if (voxels.idx_w == mvad_pkg::IDX_DIRECT)
            per_cell = voxels.color_len(voxels.fmt);
        else if (voxels.pal_size == 1)
            per_cell = 1;
        else
            per_cell = voxels.index_len(voxels.idx_w);
        lim = (voxels.pal_size > PAL_DEPTH) ? PAL_DEPTH : voxels.pal_size;
        for (int a = 0; a < n_arrays; a++)
        begin
            start_array();
            for (longint unsigned c = 0; c < n_cells + 2; c++)
            begin
                if ($urandom_range(0, 99) < 4)
                begin
                    it = make_item($urandom_range(0, 2));
                    if (it.cmd == mvad_pkg::CMD_EXIST && $urandom_range(0, 3) != 0)
                        it.table_addr = $urandom_range(0, map_len - 1);
                    send_item(it);
                end
                if (lim > 1 && $urandom_range(0, 99) < 85)
                    idx = $urandom_range(0, lim - 1);
                else
                    idx = $urandom;
                for (int b = per_cell - 1; b >= 0; b--)
                    send_byte(voxels.idx_w == mvad_pkg::IDX_DIRECT ? $urandom_range(0, 255)
                                                                   : idx[8 * b +: 8]);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = mvad_pkg::CMD_PAL;
        in_ch.byte_in = '0;
        in_ch.table_addr = '0;
        in_ch.palette_word = '0;
        in_ch.origin_x = '0;
        in_ch.origin_y = '0;
        in_ch.origin_z = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stall_left = 0;
        idle_cycles = 0;
        items_sent = 0;
        arrays_started = 0;
        phases_run = 0;
        calm = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A content byte before any array start must be dropped silently.
        send_byte(8'hA5);

        // Fill the palette and the front of the bitmap. Masked arrays are kept small
        // enough that no walk reads past the filled bytes. The bitmap starts all
        // clear; the palette holds random colors with both extremes.
        for (int i = 0; i < PAL_DEPTH; i++)
            send_table(mvad_pkg::CMD_PAL, i,
                       (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
        send_table(mvad_pkg::CMD_PAL, 4095, 32'h1234_5678);
        for (int i = 0; i < MAP_FILL; i++)
            send_table(mvad_pkg::CMD_EXIST, i, 32'h00);

        // Directed settings: each format and index width, the single-color palette,
        // an empty palette, a clamped palette size, zero extents, both mask modes.
        configure(mvad_pkg::FMT_ARGB, mvad_pkg::IDX_DIRECT, 9'd1, 1'b0,
                  17'd2, 17'd2, 17'd1);
        start_array();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        calm = 1'b0;
        configure(mvad_pkg::FMT_GRAY, mvad_pkg::IDX_8, 9'd1, 1'b0, 17'd0, 17'd0, 17'd3);
        run_arrays(1);
        configure(mvad_pkg::FMT_AG, mvad_pkg::IDX_32, 9'd0, 1'b1, 17'd3, 17'd1, 17'd2);
        run_arrays(1);
        configure(mvad_pkg::FMT_RGB, mvad_pkg::IDX_16, 9'd511, 1'b1, 17'd4, 17'd3, 17'd1);
        run_arrays(2);
        configure(mvad_pkg::FMT_ARGB, mvad_pkg::IDX_8, 9'd256, 1'b0, 17'd3, 17'd2, 17'd2);
        run_arrays(1);

        // Random phases; settings change between phases while the last array may
        // still be open. Masked phases keep the array within the filled bitmap.
        while (items_sent < ITEM_GOAL)
        begin
            int r;
            logic [8:0] ps;
            logic        en;
            logic [16:0] sx, sy, sz;
            r = $urandom_range(0, 9);
            ps = (r < 2) ? 9'd1 : (r < 3) ? 9'd0 : (r < 4) ? 9'd511 : $urandom_range(2, 256);
            calm = ($urandom_range(0, 3) == 0);
            en = $urandom_range(0, 1);
            sx = pick_size();
            sy = pick_size();
            sz = pick_size();
            if (en && axis_len(sx) * axis_len(sy) * axis_len(sz) > MAP_FILL * 8)
            begin
                sx = 17'($urandom_range(0, 7));
                sy = 17'($urandom_range(0, 7));
                sz = 17'($urandom_range(0, 7));
            end
            configure($urandom_range(0, 3), $urandom_range(0, 3), ps, en, sx, sy, sz);
            run_arrays($urandom_range(1, 3));
        end

        wait_quiet();
        $display("Ran %0d input transfers over %0d arrays in %0d register settings.",
                 items_sent, arrays_started, phases_run);
        $display("Checked %0d results: %0d voxels, %0d done, %0d out of range, %0d capacity.",
                 voxels.checked, voxels.n_status[mvad_pkg::ST_VOXEL],
                 voxels.n_status[mvad_pkg::ST_DONE], voxels.n_status[mvad_pkg::ST_RANGE],
                 voxels.n_status[mvad_pkg::ST_CAP]);
        if (voxels.mismatches == 0 && voxels.voxel_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
